// ===== hw/rtl/lfa_pkg.sv =====
// Shared constants, entry and request types for the lazy free-list allocator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package lfa_pkg;

  localparam int GROUPS       = 4;
  localparam int NODE_ENTRIES = 64;
  localparam int SLOT_ENTRIES = 64;

  localparam int FUNC_W  = 2;
  localparam int GRP_W   = 2;
  localparam int ENT_W   = 6;
  localparam int IDX_W   = 7;

  localparam int NODE_DEPTH  = GROUPS * NODE_ENTRIES;
  localparam int NODE_AW     = $clog2(NODE_DEPTH);
  localparam int NE_W        = $clog2(NODE_ENTRIES);
  localparam int SLOT_AW     = $clog2(SLOT_ENTRIES);
  localparam int MAX_ENTRIES = (NODE_ENTRIES > SLOT_ENTRIES) ? NODE_ENTRIES : SLOT_ENTRIES;
  localparam int STEP_W      = $clog2(MAX_ENTRIES + 1);

  localparam logic [IDX_W-1:0] END_MARK = '1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_POP  = 2'd1,
    FUNC_FLAG = 2'd2,
    FUNC_NOP  = 2'd3
  } func_e;

  typedef struct packed {
    logic [IDX_W-1:0] next;
    logic             free;
    logic             unref;
  } node_ent_t;

  typedef struct packed {
    logic [IDX_W-1:0] next;
    logic             free;
  } slot_ent_t;

  typedef struct packed {
    logic               re;
    logic               we;
    logic [NODE_AW-1:0] addr;
    node_ent_t          wdata;
  } node_req_t;

  typedef struct packed {
    logic               re;
    logic               we;
    logic [SLOT_AW-1:0] addr;
    slot_ent_t          wdata;
  } slot_req_t;

  function automatic logic [IDX_W-1:0] next_dflt(input logic [IDX_W-1:0] e, input int size);
    logic [IDX_W-1:0] nxt;
    nxt = e + IDX_W'(1);
    return (int'(nxt) < size) ? nxt : END_MARK;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lfa_req_if.sv =====
// Request channel of the lazy free-list allocator: valid/ready plus request fields.
// Depends on lfa_pkg.
`default_nettype none

interface lfa_req_if;
  import lfa_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic              use_node_list;
  logic              use_slot_list;
  logic [GRP_W-1:0]  group_index;
  logic [ENT_W-1:0]  entry_index;
  logic              ref_zero;

  modport source (
    output valid, func, use_node_list, use_slot_list, group_index, entry_index, ref_zero,
    input  ready
  );

  modport sink (
    input  valid, func, use_node_list, use_slot_list, group_index, entry_index, ref_zero,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/lfa_res_if.sv =====
// Result channel of the lazy free-list allocator: valid/ready plus result fields.
// Depends on lfa_pkg.
`default_nettype none

interface lfa_res_if;
  import lfa_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [IDX_W-1:0] alloc_index;
  logic                    from_eviction;

  modport source (
    output valid, alloc_index, from_eviction,
    input  ready
  );

  modport sink (
    input  valid, alloc_index, from_eviction,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/lfa_node_store.sv =====
// Node entry store: link, free and unreferenced bits for all groups, one port.
// Unwritten entries read as their reset contents. Depends on lfa_pkg.
`default_nettype none

module lfa_node_store (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lfa_pkg::node_req_t req_i,
  output lfa_pkg::node_ent_t      rd_o
);
  import lfa_pkg::*;

  node_ent_t           mem_q [NODE_DEPTH];
  logic [NODE_DEPTH-1:0] vld_q;
  node_ent_t           rd_q;
  logic                hit_q;
  logic [NODE_AW-1:0]  addr_q;
  node_ent_t           dflt;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q   <= mem_q[req_i.addr];
      addr_q <= req_i.addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      hit_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.addr] <= 1'b1;
      end
      if (req_i.re) begin
        hit_q <= vld_q[req_i.addr];
      end
    end
  end

  always_comb begin
    dflt.next  = next_dflt(IDX_W'(addr_q[NE_W-1:0]), NODE_ENTRIES);
    dflt.free  = 1'b1;
    dflt.unref = 1'b0;
  end

  assign rd_o = hit_q ? rd_q : dflt;

endmodule

`default_nettype wire

// ===== hw/rtl/lfa_slot_store.sv =====
// Slot entry store: link and free bit of the shared slot list, one port.
// Unwritten entries read as their reset contents. Depends on lfa_pkg.
`default_nettype none

module lfa_slot_store (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lfa_pkg::slot_req_t req_i,
  output lfa_pkg::slot_ent_t      rd_o
);
  import lfa_pkg::*;

  slot_ent_t             mem_q [SLOT_ENTRIES];
  logic [SLOT_ENTRIES-1:0] vld_q;
  slot_ent_t             rd_q;
  logic                  hit_q;
  logic [SLOT_AW-1:0]    addr_q;
  slot_ent_t             dflt;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q   <= mem_q[req_i.addr];
      addr_q <= req_i.addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      hit_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.addr] <= 1'b1;
      end
      if (req_i.re) begin
        hit_q <= vld_q[req_i.addr];
      end
    end
  end

  always_comb begin
    dflt.next = next_dflt(IDX_W'(addr_q), SLOT_ENTRIES);
    dflt.free = 1'b1;
  end

  assign rd_o = hit_q ? rd_q : dflt;

endmodule

`default_nettype wire

// ===== hw/rtl/lazy_free_list_allocator_core.sv =====
// Lazy free-list allocator: per-group node free lists and one shared slot free list.
// Depends on lfa_pkg, lfa_req_if, lfa_res_if, lfa_node_store and lfa_slot_store.
//
// Usage: requests enter on req_i (valid/ready); each request gives exactly one result
// on res_o. func 0 pushes an entry, 1 pops, 2 writes an entry's unreferenced flag.
// A pop that hands nothing out returns -1, as do push and flag writes.
// One request is worked on at a time; req_i.ready is high only while the sequencer
// is idle. A request walks its list through a single-port entry store, with a read
// and an evaluate step per entry visited. An unused func, an empty select or a group
// or entry out of range goes straight to the result; a slot push writes the entry
// without a read; a node push and a flag write read the entry, then write it. A pop
// reads and evaluates entries until it finds a free one, reaches the end mark or is
// cut at the list size; a node pop that finds no free entry then evicts the first
// unreferenced entry it passed, reading and writing it.
// The sequencer returns to idle as the result enters the output register.
// Reset restores every list to its full, ascending order; no clearing pass runs,
// the stores keep a written bit per entry. A stalled receiver holds the result in
// the output register; the next request is still accepted and worked on, and its
// result waits until the register empties.
`default_nettype none

module lazy_free_list_allocator_core (
  input wire logic clk_i,
  input wire logic rst_ni,
  lfa_req_if.sink   req_i,
  lfa_res_if.source res_o
);
  import lfa_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOOK = 6'b000010,
    S_EVAL = 6'b000100,
    S_EVRD = 6'b001000,
    S_EVWR = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_NPUSH = 3'd1,
    OP_SPUSH = 3'd2,
    OP_FLAG  = 3'd3,
    OP_NPOP  = 3'd4,
    OP_SPOP  = 3'd5
  } op_e;

  state_e             state_q, state_d;
  op_e                op_q, op_d, acc_op;
  logic [GRP_W-1:0]   grp_q, grp_d;
  logic [ENT_W-1:0]   ent_q, ent_d;
  logic               rz_q, rz_d;
  logic [IDX_W-1:0]   cur_q, cur_d;
  logic [IDX_W-1:0]   cand_q, cand_d;
  logic [STEP_W-1:0]  steps_q, steps_d;
  logic [IDX_W-1:0]   res_idx_q, res_idx_d;
  logic               res_ev_q, res_ev_d;
  logic [IDX_W-1:0]   node_head_q [GROUPS];
  logic [IDX_W-1:0]   node_head_d [GROUPS];
  logic [IDX_W-1:0]   slot_head_q, slot_head_d;
  logic               out_vld_q;
  logic [IDX_W-1:0]   out_idx_q;
  logic               out_ev_q;
  logic               out_load;
  logic               grp_ok;

  node_req_t          node_req;
  node_ent_t          node_rd;
  slot_req_t          slot_req;
  slot_ent_t          slot_rd;
  logic [NODE_AW-1:0] naddr_ent, naddr_cur, naddr_cand;

  lfa_node_store u_node_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (node_req),
    .rd_o   (node_rd)
  );

  lfa_slot_store u_slot_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (slot_req),
    .rd_o   (slot_rd)
  );

  assign naddr_ent  = {grp_q, ent_q[NE_W-1:0]};
  assign naddr_cur  = {grp_q, cur_q[NE_W-1:0]};
  assign naddr_cand = {grp_q, cand_q[NE_W-1:0]};

  assign req_i.ready = (state_q == S_IDLE);
  assign out_load    = (state_q == S_DONE) && (!out_vld_q || res_o.ready);
  assign grp_ok      = int'(req_i.group_index) < GROUPS;

  always_comb begin
    acc_op = OP_NONE;
    case (req_i.func)
      FUNC_PUSH: begin
        if (req_i.use_node_list) begin
          if (grp_ok && int'(req_i.entry_index) < NODE_ENTRIES) acc_op = OP_NPUSH;
        end else if (req_i.use_slot_list && int'(req_i.entry_index) < SLOT_ENTRIES) begin
          acc_op = OP_SPUSH;
        end
      end
      FUNC_POP: begin
        if (req_i.use_node_list) begin
          if (grp_ok) acc_op = OP_NPOP;
        end else if (req_i.use_slot_list) begin
          acc_op = OP_SPOP;
        end
      end
      FUNC_FLAG: begin
        if (grp_ok && int'(req_i.entry_index) < NODE_ENTRIES) acc_op = OP_FLAG;
      end
      default: acc_op = OP_NONE;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    grp_d       = grp_q;
    ent_d       = ent_q;
    rz_d        = rz_q;
    cur_d       = cur_q;
    cand_d      = cand_q;
    steps_d     = steps_q;
    res_idx_d   = res_idx_q;
    res_ev_d    = res_ev_q;
    node_head_d = node_head_q;
    slot_head_d = slot_head_q;
    node_req    = '0;
    slot_req    = '0;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d      = acc_op;
          grp_d     = req_i.group_index;
          ent_d     = req_i.entry_index;
          rz_d      = req_i.ref_zero;
          cur_d     = req_i.use_node_list ? node_head_q[req_i.group_index] : slot_head_q;
          cand_d    = END_MARK;
          steps_d   = '0;
          res_idx_d = END_MARK;
          res_ev_d  = 1'b0;
          state_d   = (acc_op == OP_NONE) ? S_DONE : S_LOOK;
        end
      end
      S_LOOK: begin
        case (op_q)
          OP_NPUSH, OP_FLAG: begin
            node_req.re   = 1'b1;
            node_req.addr = naddr_ent;
            state_d       = S_EVAL;
          end
          OP_SPUSH: begin
            slot_req.we         = 1'b1;
            slot_req.addr       = ent_q[SLOT_AW-1:0];
            slot_req.wdata.next = slot_head_q;
            slot_req.wdata.free = 1'b1;
            slot_head_d         = IDX_W'(ent_q);
            state_d             = S_DONE;
          end
          OP_NPOP: begin
            if (cur_q >= IDX_W'(NODE_ENTRIES)) begin
              node_head_d[grp_q] = END_MARK;
              state_d            = (cand_q != END_MARK) ? S_EVRD : S_DONE;
            end else begin
              node_req.re   = 1'b1;
              node_req.addr = naddr_cur;
              state_d       = S_EVAL;
            end
          end
          OP_SPOP: begin
            if (cur_q >= IDX_W'(SLOT_ENTRIES)) begin
              slot_head_d = END_MARK;
              state_d     = S_DONE;
            end else begin
              slot_req.re   = 1'b1;
              slot_req.addr = cur_q[SLOT_AW-1:0];
              state_d       = S_EVAL;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_EVAL: begin
        case (op_q)
          OP_NPUSH: begin
            node_req.we          = 1'b1;
            node_req.addr        = naddr_ent;
            node_req.wdata.next  = node_head_q[grp_q];
            node_req.wdata.free  = 1'b1;
            node_req.wdata.unref = node_rd.unref;
            node_head_d[grp_q]   = IDX_W'(ent_q);
            state_d              = S_DONE;
          end
          OP_FLAG: begin
            node_req.we          = 1'b1;
            node_req.addr        = naddr_ent;
            node_req.wdata       = node_rd;
            node_req.wdata.unref = rz_q;
            state_d              = S_DONE;
          end
          OP_NPOP: begin
            if (node_rd.free) begin
              node_req.we         = 1'b1;
              node_req.addr       = naddr_cur;
              node_req.wdata      = node_rd;
              node_req.wdata.free = 1'b0;
              node_head_d[grp_q]  = node_rd.next;
              res_idx_d           = cur_q;
              state_d             = S_DONE;
            end else if (steps_q >= STEP_W'(NODE_ENTRIES)) begin
              node_head_d[grp_q] = END_MARK;
              state_d            = (cand_q != END_MARK) ? S_EVRD : S_DONE;
            end else begin
              if (cand_q == END_MARK && node_rd.unref) cand_d = cur_q;
              cur_d   = node_rd.next;
              steps_d = steps_q + STEP_W'(1);
              state_d = S_LOOK;
            end
          end
          OP_SPOP: begin
            if (slot_rd.free) begin
              slot_req.we         = 1'b1;
              slot_req.addr       = cur_q[SLOT_AW-1:0];
              slot_req.wdata      = slot_rd;
              slot_req.wdata.free = 1'b0;
              slot_head_d         = slot_rd.next;
              res_idx_d           = cur_q;
              state_d             = S_DONE;
            end else if (steps_q >= STEP_W'(SLOT_ENTRIES)) begin
              slot_head_d = END_MARK;
              state_d     = S_DONE;
            end else begin
              cur_d   = slot_rd.next;
              steps_d = steps_q + STEP_W'(1);
              state_d = S_LOOK;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_EVRD: begin
        node_req.re   = 1'b1;
        node_req.addr = naddr_cand;
        state_d       = S_EVWR;
      end
      S_EVWR: begin
        node_req.we         = 1'b1;
        node_req.addr       = naddr_cand;
        node_req.wdata      = node_rd;
        node_req.wdata.free = 1'b0;
        node_head_d[grp_q]  = node_rd.next;
        res_idx_d           = cand_q;
        res_ev_d            = 1'b1;
        state_d             = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_NONE;
      node_head_q <= '{default: '0};
      slot_head_q <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      node_head_q <= node_head_d;
      slot_head_q <= slot_head_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q     <= grp_d;
    ent_q     <= ent_d;
    rz_q      <= rz_d;
    cur_q     <= cur_d;
    cand_q    <= cand_d;
    steps_q   <= steps_d;
    res_idx_q <= res_idx_d;
    res_ev_q  <= res_ev_d;
    if (out_load) begin
      out_idx_q <= res_idx_q;
      out_ev_q  <= res_ev_q;
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.alloc_index   = out_idx_q;
  assign res_o.from_eviction = out_ev_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.from_eviction |-> res_o.alloc_index != END_MARK)
    else $error("eviction result without an entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> state_q != S_IDLE)
    else $error("sequencer stayed idle after a request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(node_req.re && node_req.we) && !(slot_req.re && slot_req.we))
    else $error("entry store read and written in one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EVRD |-> op_q == OP_NPOP && cand_q != END_MARK)
    else $error("eviction without a candidate");

endmodule

`default_nettype wire
